@@ rtl/accumulator_cpu_execute_macros.svh @@
// ----------------------------------------------------------------------------
// accumulator_cpu_execute_macros.svh
// Assertion macros used by the checker of the accumulator execute block.
// ----------------------------------------------------------------------------
`ifndef ACCUMULATOR_CPU_EXECUTE_MACROS_SVH
`define ACCUMULATOR_CPU_EXECUTE_MACROS_SVH

// Same-cycle implication, checked out of reset
`define ACPU_ASSERT_NOW(label, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

// Next-cycle implication, checked out of reset
`define ACPU_ASSERT_NEXT(label, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

@@ rtl/acpu_pkg.sv @@
// ----------------------------------------------------------------------------
// acpu_pkg
// Types and codes shared by the accumulator execute block.
// ----------------------------------------------------------------------------
package acpu_pkg;

    // Instruction opcodes
    typedef enum logic [7:0] {
        OP_LDM = 8'h00,
        OP_LDI = 8'h01,
        OP_STM = 8'h02,
        OP_ADD = 8'h03,
        OP_SUB = 8'h04,
        OP_MUL = 8'h05,
        OP_DIV = 8'h06,
        OP_INC = 8'h07,
        OP_DEC = 8'h08,
        OP_AND = 8'h09,
        OP_OR  = 8'h0A,
        OP_NOT = 8'h0B,
        OP_JMP = 8'h0C,
        OP_JZ  = 8'h0D,
        OP_JNZ = 8'h0E,
        OP_JG  = 8'h0F,
        OP_JL  = 8'h10,
        OP_JGE = 8'h11,
        OP_JLE = 8'h12,
        OP_HLT = 8'h13
    } opcode_t;

    // Fault codes reported with each result
    typedef enum logic [1:0] {
        FLT_NONE   = 2'd0,
        FLT_OPCODE = 2'd1,
        FLT_DIVZ   = 2'd2
    } fault_t;

    // Sequencer states
    typedef enum logic [2:0] {
        ST_IDLE,
        ST_READ,
        ST_EXEC,
        ST_DIV,
        ST_DFIN
    } state_t;

    // Divider step count
    localparam int unsigned DIV_STEPS = 8;

    // Controller to datapath
    typedef struct packed {
        logic load_inst;
        logic div_start;
        logic div_step;
        logic commit;
    } cmd_t;

    // Datapath to controller
    typedef struct packed {
        logic div_go;
    } sts_t;

    // Result word, next_pc in the lowest bits
    typedef struct packed {
        logic [3:0]        pad;
        fault_t            fault_code;
        logic              halted;
        logic              status_flag;
        logic signed [7:0] accumulator;
        logic [7:0]        next_pc;
    } result_t;

endpackage

@@ rtl/acpu_ctrl.sv @@
// ----------------------------------------------------------------------------
// acpu_ctrl
// Instruction sequencer: fetch-word accept, store read, execute, divide
// iterations, commit, and the output word valid flag.
// ----------------------------------------------------------------------------
module acpu_ctrl
    import acpu_pkg::*;
(
    input  logic clk,
    input  logic rst_n,
    input  logic in_valid,
    output logic in_ready,
    output logic out_valid,
    input  logic out_ready,
    input  sts_t sts,
    output cmd_t cmd
);

    localparam int CW = $clog2(DIV_STEPS);

    state_t          state_reg, state_next;
    logic [CW-1:0]   cnt_reg, cnt_next;
    logic            ovld_reg, ovld_next;
    logic            out_free;

    assign out_free = !ovld_reg || out_ready;

    // Next state
    always_comb
    begin
        state_next = state_reg;
        case (state_reg)
            ST_IDLE:
            begin
                if (in_valid)
                    state_next = ST_READ;
            end
            ST_READ:
                state_next = ST_EXEC;
            ST_EXEC:
            begin
                if (sts.div_go)
                    state_next = ST_DIV;
                else if (out_free)
                    state_next = ST_IDLE;
            end
            ST_DIV:
            begin
                if (cnt_reg == CW'(DIV_STEPS - 1))
                    state_next = ST_DFIN;
            end
            ST_DFIN:
            begin
                if (out_free)
                    state_next = ST_IDLE;
            end
            default:
                state_next = ST_IDLE;
        endcase
    end

    // Outputs and commands
    always_comb
    begin
        cmd      = '0;
        in_ready = 1'b0;
        cnt_next = cnt_reg;
        case (state_reg)
            ST_IDLE:
            begin
                in_ready      = 1'b1;
                cmd.load_inst = in_valid;
            end
            ST_EXEC:
            begin
                if (sts.div_go)
                begin
                    cmd.div_start = 1'b1;
                    cnt_next      = '0;
                end
                else
                    cmd.commit = out_free;
            end
            ST_DIV:
            begin
                cmd.div_step = 1'b1;
                cnt_next     = cnt_reg + 1'b1;
            end
            ST_DFIN:
                cmd.commit = out_free;
            default:
                cmd = '0;
        endcase
    end

    // Output word valid
    always_comb
    begin
        if (cmd.commit)
            ovld_next = 1'b1;
        else if (out_ready)
            ovld_next = 1'b0;
        else
            ovld_next = ovld_reg;
    end

    assign out_valid = ovld_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= ST_IDLE;
            cnt_reg   <= '0;
            ovld_reg  <= 1'b0;
        end
        else
        begin
            state_reg <= state_next;
            cnt_reg   <= cnt_next;
            ovld_reg  <= ovld_next;
        end
    end

endmodule

@@ rtl/acpu_div.sv @@
// ----------------------------------------------------------------------------
// acpu_div
// Restoring divider on 8-bit magnitudes, one quotient bit per step.
// ----------------------------------------------------------------------------
module acpu_div
    import acpu_pkg::*;
(
    input  logic       clk,
    input  logic       start,
    input  logic       step,
    input  logic [7:0] dividend,
    input  logic [7:0] divisor,
    output logic [7:0] quotient
);

    logic [7:0] rem_reg, rem_next;
    logic [7:0] quo_reg, quo_next;
    logic [7:0] dvs_reg, dvs_next;
    logic [8:0] shifted;
    logic [8:0] diff;
    logic       ge;

    // Operand load on start, else one shift-subtract step
    always_comb
    begin
        shifted  = {rem_reg, quo_reg[7]};
        diff     = shifted - {1'b0, dvs_reg};
        ge       = shifted >= {1'b0, dvs_reg};
        rem_next = rem_reg;
        quo_next = quo_reg;
        dvs_next = dvs_reg;
        if (start)
        begin
            rem_next = '0;
            quo_next = dividend;
            dvs_next = divisor;
        end
        else if (step)
        begin
            rem_next = ge ? diff[7:0] : shifted[7:0];
            quo_next = {quo_reg[6:0], ge};
        end
    end

    always_ff @(posedge clk)
    begin
        rem_reg <= rem_next;
        quo_reg <= quo_next;
        dvs_reg <= dvs_next;
    end

    assign quotient = quo_reg;

endmodule

@@ rtl/acpu_dp.sv @@
// ----------------------------------------------------------------------------
// acpu_dp
// Execute datapath: instruction latch, pc, accumulator, status and halt
// registers, data store with per-entry valid bits, ALU and result register.
// ----------------------------------------------------------------------------
module acpu_dp
    import acpu_pkg::*;
#(
    parameter int DATA_DEPTH = 256
)
(
    input  logic        clk,
    input  logic        rst_n,
    input  logic [7:0]  opcode,
    input  logic [7:0]  operand,
    input  cmd_t        cmd,
    output sts_t        sts,
    output result_t     result
);

    localparam int AW = $clog2(DATA_DEPTH);

    logic [7:0]          opc_reg;
    logic signed [7:0]   opr_reg;
    logic [7:0]          pc_reg, pc_next;
    logic signed [7:0]   acc_reg, acc_next;
    logic                stat_reg, stat_next;
    logic                halt_reg, halt_next;
    logic [7:0]          mem_q_reg;
    logic                vld_q_reg;
    result_t             res_reg;

    logic [7:0]          mem [DATA_DEPTH];
    logic [DATA_DEPTH-1:0] vld_reg;

    logic [AW-1:0]       addr_lut [256];
    logic [AW-1:0]       addr;
    logic signed [7:0]   a;
    logic signed [7:0]   m;
    logic signed [15:0]  prod;
    logic [7:0]          a_mag;
    logic [7:0]          m_mag;
    logic [7:0]          quo_mag;
    logic signed [7:0]   quo;
    logic [7:0]          pc_inc1;
    logic [7:0]          pc_inc2;
    logic                store;
    fault_t              fault;
    logic signed [7:0]   r_tmp;

    // Carry and overflow terms of the status bit
    function automatic logic flag_set(input logic signed [7:0] fa,
                                      input logic signed [7:0] fb,
                                      input logic signed [7:0] fr,
                                      input logic            use_carry);
        logic signed [8:0] s;
        logic carry;
        logic ovf;
        s     = {fa[7], fa} + {fb[7], fb};
        carry = s[8] != s[7];
        ovf   = (!fa[7] && fa != 0 && !fb[7] && fb != 0 && fr[7]) ||
                (fa[7] && fb[7] && !fr[7] && fr != 0);
        return (use_carry && carry) || ovf;
    endfunction

    // Operand to store address, reduced at elaboration
    for (genvar i = 0; i < 256; i++)
    begin : g_addr
        localparam int unsigned AIDX = i % DATA_DEPTH;
        assign addr_lut[i] = AIDX[AW-1:0];
    end

    // Raw operand bits index the table
    assign addr = addr_lut[$unsigned(opr_reg)];

    // Instruction latch
    always_ff @(posedge clk)
    begin
        if (cmd.load_inst)
        begin
            opc_reg <= opcode;
            opr_reg <= operand;
        end
    end

    // Data store, registered read
    always_ff @(posedge clk)
    begin
        if (cmd.commit && store)
            mem[addr] <= acc_reg;
        mem_q_reg <= mem[addr];
    end

    // Entry valid bits; an unwritten entry reads as zero
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            vld_reg   <= '0;
            vld_q_reg <= 1'b0;
        end
        else
        begin
            if (cmd.commit && store)
                vld_reg[addr] <= 1'b1;
            vld_q_reg <= vld_reg[addr];
        end
    end

    assign a = acc_reg;
    assign m = vld_q_reg ? mem_q_reg : 8'sd0;

    // Divider on magnitudes, sign fixed afterwards
    assign a_mag = a[7] ? (~a + 8'd1) : a;
    assign m_mag = m[7] ? (~m + 8'd1) : m;

    acpu_div u_div (
        .clk      (clk),
        .start    (cmd.div_start),
        .step     (cmd.div_step),
        .dividend (a_mag),
        .divisor  (m_mag),
        .quotient (quo_mag)
    );

    assign quo = (a[7] ^ m[7]) ? (~quo_mag + 8'd1) : quo_mag;

    assign sts.div_go = !halt_reg && (opc_reg == OP_DIV) && (m != 8'sd0);

    assign prod    = a * m;
    assign pc_inc1 = pc_reg + 8'd1;
    assign pc_inc2 = pc_reg + 8'd2;

    // Instruction execute
    always_comb
    begin
        pc_next   = pc_inc1;
        acc_next  = a;
        stat_next = stat_reg;
        halt_next = halt_reg;
        store     = 1'b0;
        fault     = FLT_NONE;
        r_tmp     = a;
        case (opcode_t'(opc_reg))
            OP_LDM: acc_next = m;
            OP_LDI: acc_next = opr_reg;
            OP_STM: store = 1'b1;
            OP_ADD:
            begin
                r_tmp     = a + m;
                acc_next  = r_tmp;
                stat_next = stat_reg | flag_set(a, m, r_tmp, 1'b1);
            end
            OP_SUB:
            begin
                r_tmp     = a - m;
                acc_next  = r_tmp;
                stat_next = stat_reg | flag_set(a, m, r_tmp, 1'b1);
            end
            OP_MUL:
            begin
                r_tmp     = prod[7:0];
                acc_next  = r_tmp;
                stat_next = stat_reg | flag_set(a, m, r_tmp, 1'b0);
            end
            OP_DIV:
            begin
                if (m == 8'sd0)
                    fault = FLT_DIVZ;
                else
                    acc_next = quo;
            end
            OP_INC:
            begin
                r_tmp     = a + 8'sd1;
                acc_next  = r_tmp;
                stat_next = stat_reg | flag_set(a, 8'sd1, r_tmp, 1'b1);
            end
            OP_DEC:
            begin
                r_tmp     = a - 8'sd1;
                acc_next  = r_tmp;
                stat_next = stat_reg | flag_set(a, -8'sd1, r_tmp, 1'b1);
            end
            OP_AND: acc_next = a & m;
            OP_OR:  acc_next = a | m;
            OP_NOT: acc_next = ~a;
            OP_JMP: pc_next = opr_reg;
            OP_JZ:  pc_next = (a == 8'sd0) ? opr_reg : pc_inc2;
            OP_JNZ: pc_next = (a != 8'sd0) ? opr_reg : pc_inc2;
            OP_JG:  pc_next = (a > 8'sd0) ? opr_reg : pc_inc2;
            OP_JL:  pc_next = (a < 8'sd0) ? opr_reg : pc_inc2;
            OP_JGE: pc_next = (a >= 8'sd0) ? opr_reg : pc_inc2;
            OP_JLE: pc_next = (a <= 8'sd0) ? opr_reg : pc_inc2;
            OP_HLT:
            begin
                pc_next   = pc_reg;
                halt_next = 1'b1;
                stat_next = stat_reg | (a == 8'sd0);
            end
            default: fault = FLT_OPCODE;
        endcase

        // Fault: halt, architectural state untouched
        if (fault != FLT_NONE)
        begin
            pc_next   = pc_reg;
            acc_next  = a;
            stat_next = stat_reg;
            halt_next = 1'b1;
            store     = 1'b0;
        end

        // Halted machine ignores the instruction
        if (halt_reg)
        begin
            pc_next   = pc_reg;
            acc_next  = a;
            stat_next = stat_reg;
            halt_next = 1'b1;
            store     = 1'b0;
            fault     = FLT_NONE;
        end
    end

    // Architectural state
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            pc_reg   <= '0;
            acc_reg  <= '0;
            stat_reg <= 1'b0;
            halt_reg <= 1'b0;
        end
        else if (cmd.commit)
        begin
            pc_reg   <= pc_next;
            acc_reg  <= acc_next;
            stat_reg <= stat_next;
            halt_reg <= halt_next;
        end
    end

    // Result word register
    always_ff @(posedge clk)
    begin
        if (cmd.commit)
        begin
            res_reg.pad         <= '0;
            res_reg.fault_code  <= fault;
            res_reg.halted      <= halt_next;
            res_reg.status_flag <= stat_next;
            res_reg.accumulator <= acc_next;
            res_reg.next_pc     <= pc_next;
        end
    end

    assign result = res_reg;

endmodule

@@ rtl/accumulator_cpu_execute.sv @@
// ----------------------------------------------------------------------------
// accumulator_cpu_execute
// Execute stage of an 8-bit signed accumulator machine with a data store.
// ----------------------------------------------------------------------------
// One instruction word in gives one result word out. An ordinary instruction
// passes through accept, a registered data store read and execute, where its
// result word is registered; a divide adds the 8 steps of the shift-subtract
// divider and a final commit state before its result is registered. The next
// instruction is accepted as soon as the previous one has executed, while its
// result may still wait in the output register; a result that is still
// waiting holds the following instruction in its execute cycle. The data
// store keeps one valid bit per entry, so it needs no clearing pass after
// reset and an unwritten entry reads as zero.
module accumulator_cpu_execute
    import acpu_pkg::*;
#(
    parameter int DATA_DEPTH = 256
)
(
    input  logic        clk,
    input  logic        rst_n,
    input  logic        s_axis_tvalid,
    output logic        s_axis_tready,
    input  logic [15:0] s_axis_tdata,   // opcode[7:0], operand[15:8]
    output logic        m_axis_tvalid,
    input  logic        m_axis_tready,
    output logic [23:0] m_axis_tdata    // next_pc[7:0], accumulator[15:8],
                                        // status_flag[16], halted[17],
                                        // fault_code[19:18], zero[23:20]
);

    cmd_t    cmd;
    sts_t    sts;
    result_t result;

    acpu_ctrl u_ctrl (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (s_axis_tvalid),
        .in_ready  (s_axis_tready),
        .out_valid (m_axis_tvalid),
        .out_ready (m_axis_tready),
        .sts       (sts),
        .cmd       (cmd)
    );

    acpu_dp #(
        .DATA_DEPTH (DATA_DEPTH)
    ) u_dp (
        .clk     (clk),
        .rst_n   (rst_n),
        .opcode  (s_axis_tdata[7:0]),
        .operand (s_axis_tdata[15:8]),
        .cmd     (cmd),
        .sts     (sts),
        .result  (result)
    );

    assign m_axis_tdata = result;

endmodule

@@ rtl/acpu_checker.sv @@
// ----------------------------------------------------------------------------
// acpu_checker
// Port-level checks of the accumulator execute block, bound to the top level.
// ----------------------------------------------------------------------------
`include "accumulator_cpu_execute_macros.svh"

module acpu_checker
    import acpu_pkg::*;
(
    input logic        clk,
    input logic        rst_n,
    input logic        m_axis_tvalid,
    input logic        m_axis_tready,
    input logic [23:0] m_axis_tdata
);

    result_t res;
    logic    out_acc;
    logic    halt_seen_reg, halt_seen_next;
    logic    stat_seen_reg, stat_seen_next;

    assign res     = m_axis_tdata;
    assign out_acc = m_axis_tvalid && m_axis_tready;

    // Remember halt and status from delivered words
    always_comb
    begin
        halt_seen_next = halt_seen_reg | (out_acc && res.halted);
        stat_seen_next = stat_seen_reg | (out_acc && res.status_flag);
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            halt_seen_reg <= 1'b0;
            stat_seen_reg <= 1'b0;
        end
        else
        begin
            halt_seen_reg <= halt_seen_next;
            stat_seen_reg <= stat_seen_next;
        end
    end

    // Stalled result word holds
    `ACPU_ASSERT_NEXT(a_out_hold, m_axis_tvalid && !m_axis_tready,
                      m_axis_tvalid && $stable(m_axis_tdata), "result word changed under stall")

    // Once halted, every later word is halted with no fault
    `ACPU_ASSERT_NOW(a_halt_sticky, out_acc && halt_seen_reg,
                     res.halted && res.fault_code == FLT_NONE, "halt not sticky")

    // Status bit never clears
    `ACPU_ASSERT_NOW(a_stat_sticky, out_acc && stat_seen_reg,
                     res.status_flag, "status bit cleared")

    // A fault always halts the machine
    `ACPU_ASSERT_NOW(a_fault_halts, m_axis_tvalid && res.fault_code != FLT_NONE,
                     res.halted, "fault without halt")

endmodule

bind accumulator_cpu_execute acpu_checker u_acpu_checker (.*);

@@ tb/sv/acpu_exec_checker.sv @@
// ----------------------------------------------------------------------------
// acpu_exec_checker
// Watches both stream channels of the accumulator execute block, predicts
// each result word from the accepted instruction word and compares them.
// ----------------------------------------------------------------------------
module acpu_exec_checker
    import acpu_pkg::*;
#(
    parameter int DEPTH = 256
)
(
    input  logic        clk,
    input  logic        rst_n,
    input  logic        s_axis_tvalid,
    input  logic        s_axis_tready,
    input  logic [15:0] s_axis_tdata,   // opcode[7:0], operand[15:8]
    input  logic        m_axis_tvalid,
    input  logic        m_axis_tready,
    input  logic [23:0] m_axis_tdata,   // next_pc[7:0], accumulator[15:8],
                                        // status_flag[16], halted[17],
                                        // fault_code[19:18], zero[23:20]
    output int          errors,
    output int          pending
);
    timeunit 1ns;
    timeprecision 1ps;

    // Shadow machine state
    logic [7:0] pc_q;
    logic [7:0] acc_q;
    bit         status_q;
    bit         halt_q;
    logic [7:0] data_mem [DEPTH];

    // Result words still owed by the block, oldest first
    result_t    expected_results [$];

    initial
    begin
        pc_q     = '0;
        acc_q    = '0;
        status_q = 1'b0;
        halt_q   = 1'b0;
        errors   = 0;
        pending  = 0;
        for (int i = 0; i < DEPTH; i++)
        begin
            data_mem[i] = '0;
        end
    end

    // Two's complement wrap to 8 bits, sign-extended back to int
    function automatic int wrap8(int x);
        logic signed [7:0] t;
        t = x[7:0];
        return t;
    endfunction

    // Carry and overflow terms as the status bit collects them; the carry term
    // is always formed with a + b, even for subtract; multiply leaves it out
    function automatic bit status_term(int a, int b, int r, bit with_carry);
        bit carry;
        bit ovf;
        carry = (a > 127 - b) || (a < -128 - b);
        ovf   = (a > 0 && b > 0 && r < 0) || (a < 0 && b < 0 && r > 0);
        return (with_carry && carry) || ovf;
    endfunction

    // Execute one instruction word on the shadow state, return the result word
    function automatic result_t execute_word(logic [7:0] opc, logic [7:0] raw);
        int         a;
        int         m;
        int         res;
        int         addr;
        logic [7:0] npc;
        logic [7:0] pc_skip;
        fault_t     flt;
        result_t    word;
        addr    = raw % DEPTH;
        a       = $signed(acc_q);
        m       = $signed(data_mem[addr]);
        res     = a;
        flt     = FLT_NONE;
        npc     = pc_q + 8'd1;
        pc_skip = pc_q + 8'd2;
        if (!halt_q)
        begin
            case (opc)
                OP_LDM: res = m;
                OP_LDI: res = $signed(raw);
                OP_STM: data_mem[addr] = acc_q;
                OP_ADD:
                begin
                    status_q |= status_term(a, m, wrap8(a + m), 1'b1);
                    res = a + m;
                end
                OP_SUB:
                begin
                    status_q |= status_term(a, m, wrap8(a - m), 1'b1);
                    res = a - m;
                end
                OP_MUL:
                begin
                    status_q |= status_term(a, m, wrap8(a * m), 1'b0);
                    res = a * m;
                end
                OP_DIV:
                begin
                    // int division truncates toward zero; -128 / -1 wraps below
                    if (m == 0)
                    begin
                        flt = FLT_DIVZ;
                    end
                    else
                    begin
                        res = a / m;
                    end
                end
                OP_INC:
                begin
                    status_q |= status_term(a, 1, wrap8(a + 1), 1'b1);
                    res = a + 1;
                end
                OP_DEC:
                begin
                    status_q |= status_term(a, -1, wrap8(a - 1), 1'b1);
                    res = a - 1;
                end
                OP_AND: res = a & m;
                OP_OR:  res = a | m;
                OP_NOT: res = ~a;
                OP_JMP: npc = raw;
                OP_JZ:  npc = (a == 0) ? raw : pc_skip;
                OP_JNZ: npc = (a != 0) ? raw : pc_skip;
                OP_JG:  npc = (a > 0)  ? raw : pc_skip;
                OP_JL:  npc = (a < 0)  ? raw : pc_skip;
                OP_JGE: npc = (a >= 0) ? raw : pc_skip;
                OP_JLE: npc = (a <= 0) ? raw : pc_skip;
                OP_HLT:
                begin
                    npc    = pc_q;
                    halt_q = 1'b1;
                    if (a == 0)
                    begin
                        status_q = 1'b1;
                    end
                end
                default: flt = FLT_OPCODE;
            endcase
            // A fault leaves pc and acc where they were
            if (flt != FLT_NONE)
            begin
                halt_q = 1'b1;
            end
            else
            begin
                pc_q  = npc;
                acc_q = res[7:0];
            end
        end
        word             = '0;
        word.next_pc     = pc_q;
        word.accumulator = acc_q;
        word.status_flag = status_q;
        word.halted      = halt_q;
        word.fault_code  = flt;
        return word;
    endfunction

    task automatic check_field(string name, logic [7:0] exp_v, logic [7:0] got_v);
        if (got_v !== exp_v)
        begin
            $display("%0t: %s mismatch, expected %0h, actual %0h",
                     $time, name, exp_v, got_v);
            errors++;
        end
    endtask

    // Compare result words first, then queue the prediction for a new word
    always @(posedge clk)
    begin
        result_t got;
        result_t want;
        if (rst_n)
        begin
            if (m_axis_tvalid && m_axis_tready)
            begin
                got = m_axis_tdata;
                if (expected_results.size() == 0)
                begin
                    $display("%0t: unexpected result word, expected none, actual %0h",
                             $time, m_axis_tdata);
                    errors++;
                end
                else
                begin
                    want = expected_results.pop_front();
                    check_field("next_pc", want.next_pc, got.next_pc);
                    check_field("accumulator", want.accumulator, got.accumulator);
                    check_field("status_flag", 8'(want.status_flag), 8'(got.status_flag));
                    check_field("halted", 8'(want.halted), 8'(got.halted));
                    check_field("fault_code", 8'(want.fault_code), 8'(got.fault_code));
                    check_field("pad", 8'(want.pad), 8'(got.pad));
                end
            end
            if (s_axis_tvalid && s_axis_tready)
            begin
                expected_results.push_back(execute_word(s_axis_tdata[7:0],
                                                        s_axis_tdata[15:8]));
            end
            pending = expected_results.size();
        end
    end

endmodule

@@ tb/sv/tb_accumulator_cpu_execute.sv @@
// ----------------------------------------------------------------------------
// tb_accumulator_cpu_execute
// Drives instruction words into the accumulator execute block: a directed
// program over every opcode but HLT and its corner cases, then random programs with
// guarded divides under several idle and stall mixes, and finally a halting
// word followed by words the halted block must ignore.
// ----------------------------------------------------------------------------
module tb_accumulator_cpu_execute;
    import acpu_pkg::*;

    timeunit 1ns;
    timeprecision 1ps;

    localparam int RANDOM_ITEMS = 500;
    localparam int CYCLE_LIMIT  = 200000;
    localparam int DRAIN_CYCLES = 16;

    logic        clk           = 1'b0;
    logic        rst_n         = 1'b0;
    logic        s_axis_tvalid = 1'b0;
    logic        s_axis_tready;
    logic [15:0] s_axis_tdata  = '0;     // opcode[7:0], operand[15:8]
    logic        m_axis_tvalid;
    logic        m_axis_tready = 1'b0;
    logic [23:0] m_axis_tdata;           // next_pc[7:0], accumulator[15:8],
                                         // status_flag[16], halted[17],
                                         // fault_code[19:18], zero[23:20]
    int          errors;
    int          pending;
    int          idle_pct      = 0;
    int          stall_pct     = 0;
    int          cycle_count   = 0;

    always #4 clk = ~clk;

    accumulator_cpu_execute u_dut (
        .clk           (clk),
        .rst_n         (rst_n),
        .s_axis_tvalid (s_axis_tvalid),
        .s_axis_tready (s_axis_tready),
        .s_axis_tdata  (s_axis_tdata),
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready),
        .m_axis_tdata  (m_axis_tdata)
    );

    acpu_exec_checker u_checker (
        .clk           (clk),
        .rst_n         (rst_n),
        .s_axis_tvalid (s_axis_tvalid),
        .s_axis_tready (s_axis_tready),
        .s_axis_tdata  (s_axis_tdata),
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready),
        .m_axis_tdata  (m_axis_tdata),
        .errors        (errors),
        .pending       (pending)
    );

    // Result side back-pressure
    always @(posedge clk)
    begin
        m_axis_tready <= ($urandom_range(0, 99) >= stall_pct);
    end

    // Watchdog
    always @(posedge clk)
    begin
        cycle_count <= cycle_count + 1;
        if (cycle_count == CYCLE_LIMIT)
        begin
            $display("FAIL");
            $finish;
        end
    end

    // One instruction word, with random idle cycles ahead of it
    task automatic send_word(input logic [7:0] opc, input logic [7:0] opd);
        while ($urandom_range(0, 99) < idle_pct)
        begin
            s_axis_tvalid <= 1'b0;
            @(posedge clk);
        end
        s_axis_tvalid <= 1'b1;
        s_axis_tdata  <= {opd, opc};
        @(posedge clk);
        while (!s_axis_tready)
        begin
            @(posedge clk);
        end
    endtask

    // Operands crowd the extremes so loads hit stored addresses
    function automatic logic [7:0] pick_operand();
        case ($urandom_range(0, 3))
            0:       return 8'($urandom_range(0, 7));
            1:       return 8'($urandom_range(248, 255));
            2:       return $urandom_range(0, 1) ? 8'h7F : 8'h80;
            default: return 8'($urandom_range(0, 255));
        endcase
    endfunction

    initial
    begin
        int         n_items;
        int         kind;
        logic [7:0] addr;

        repeat (12) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // Directed program: jumps both ways, divide corners, pc wrap, then
        // the status-setting arithmetic at the accumulator limits
        send_word(OP_LDM, 8'h00);
        send_word(OP_JZ,  8'h40);
        send_word(OP_JNZ, 8'h10);
        send_word(OP_JG,  8'h11);
        send_word(OP_JGE, 8'h20);
        send_word(OP_LDI, 8'h80);
        send_word(OP_STM, 8'h80);
        send_word(OP_LDI, 8'hFF);
        send_word(OP_STM, 8'hFF);
        send_word(OP_DIV, 8'h80);
        send_word(OP_LDM, 8'h80);
        send_word(OP_DIV, 8'hFF);
        send_word(OP_JL,  8'hFF);
        send_word(OP_JG,  8'h00);
        send_word(OP_NOT, 8'h00);
        send_word(OP_STM, 8'h7F);
        send_word(OP_AND, 8'h80);
        send_word(OP_JLE, 8'h33);
        send_word(OP_OR,  8'h7F);
        send_word(OP_JMP, 8'hFF);
        send_word(OP_INC, 8'h00);
        send_word(OP_DEC, 8'h00);
        send_word(OP_ADD, 8'h80);
        send_word(OP_SUB, 8'h7F);
        send_word(OP_MUL, 8'h80);

        // Random programs; a divide always follows a nonzero store to its address
        n_items = 0;
        while (n_items < RANDOM_ITEMS)
        begin
            case (n_items * 4 / RANDOM_ITEMS)
                0:
                begin
                    idle_pct  = 0;
                    stall_pct = 0;
                end
                1:
                begin
                    idle_pct  = 82;
                    stall_pct = 0;
                end
                2:
                begin
                    idle_pct  = 0;
                    stall_pct = 82;
                end
                default:
                begin
                    idle_pct  = 22;
                    stall_pct = 22;
                end
            endcase
            kind = $urandom_range(0, 18);
            if (kind == OP_DIV)
            begin
                addr = pick_operand();
                send_word(OP_LDI, 8'($urandom_range(1, 255)));
                send_word(OP_STM, addr);
                send_word(OP_LDI, pick_operand());
                send_word(OP_DIV, addr);
                n_items += 4;
            end
            else
            begin
                send_word(8'(kind), pick_operand());
                n_items++;
            end
        end

        // One way to stop the machine
        case ($urandom_range(0, 3))
            0:
            begin
                send_word(OP_LDI, 8'h00);
                send_word(OP_HLT, pick_operand());
            end
            1:
            begin
                send_word(OP_LDI, 8'($urandom_range(1, 255)));
                send_word(OP_HLT, pick_operand());
            end
            2:
            begin
                send_word(8'($urandom_range(8'h14, 8'hFF)), pick_operand());
            end
            default:
            begin
                addr = pick_operand();
                send_word(OP_LDI, 8'h00);
                send_word(OP_STM, addr);
                send_word(OP_LDI, pick_operand());
                send_word(OP_DIV, addr);
            end
        endcase

        // Halted: every word is ignored, all opcode bits exercised
        send_word(8'hFF, 8'h00);
        send_word(8'h00, 8'hFF);
        repeat (20)
        begin
            send_word(8'($urandom_range(0, 255)), 8'($urandom_range(0, 255)));
        end
        s_axis_tvalid <= 1'b0;

        @(posedge clk);
        while (pending != 0)
        begin
            @(posedge clk);
        end
        repeat (DRAIN_CYCLES) @(posedge clk);

        if (errors == 0 && pending == 0)
        begin
            $display("PASS");
        end
        else
        begin
            $display("FAIL");
        end
        $finish;
    end

endmodule
